// ----- rtl/core/bte_pkg.sv -----
// Shared types, constants and helpers of the batched throughput estimator.
package bte_pkg;

   localparam int ALPHA_W    = 17;
   localparam int BATCH_W    = 16;
   localparam int BYTES_W    = 16;
   localparam int TIME_W     = 32;
   localparam int EST_W      = 48;
   localparam int TOTAL_W    = 40;
   localparam int ACC_W      = 64;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 4;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
   localparam logic [BATCH_W-1:0] BATCH_RESET = 16'd64;

   // bits per second = bytes * 8e6 / us = (bytes * 15625) << 9 / us
   localparam logic [ALPHA_W-1:0] SCALE_MULT  = 17'd15625;
   localparam int                 SCALE_SHIFT = 9;

   // step counts of the shared unit
   localparam int SCALE_STEPS      = 14;
   localparam int SAMPLE_DIV_STEPS = 63;
   localparam int WEIGHT_STEPS     = 17;
   localparam int COUNT_MUL_STEPS  = 16;
   localparam int ALPHA_DIV_STEPS  = 33;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_RTT    = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ALPHA = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE = 4'd1;

   localparam logic RESULT_BATCH    = 1'b0;
   localparam logic RESULT_DOWNLOAD = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV_SAMPLE,
      ST_WEIGHT_OLD,
      ST_WEIGHT_NEW,
      ST_ALPHA_MUL,
      ST_ALPHA_DIV,
      ST_FINISH
   } state_type;

   function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
      clamp_alpha = (a > ALPHA_ONE) ? ALPHA_ONE : a;
   endfunction

endpackage

// ----- rtl/core/batched_throughput_estimator_top.sv -----
// Batched throughput estimator: event intake, sequencer and shared add/sub unit.
//
// Usage:
//   req_* carries one event item: kind (start, data received, rtt update,
//   download finished), packet size and a microsecond timestamp.
//   rsp_* carries at most one result item per event: the updated estimate in
//   bits per second, the download time and the result kind.
//   csr_* writes base_alpha (index 0) and batch_size (index 1); csr_ready is
//   always high, other indexes are dropped. Write only while the block idles.
// Timing:
//   Start and data items, and rtt updates that do not close a batch, leave
//   the block idle. A closed batch or a download finish runs the sequencer
//   over one 64-bit adder/subtractor, one bit per cycle: a scaling multiply,
//   a restoring divide for the sample, an EWMA multiply (old then new
//   weight) when the estimate is nonzero, and for a download finish a
//   multiply and divide to rescale alpha, then the finish state.
// Reset: synchronous, clears estimate, packet and byte counters, timestamps
//   and alpha; batch_size returns to 64, base_alpha to 0; no result is pending.
// Stalls: a result sits in the output register until taken. req_ready stays
//   high meanwhile; only a second result waits in the finish state for it.
module batched_throughput_estimator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic [bte_pkg::BYTES_W-1:0]          req_packet_bytes,
   input  logic [bte_pkg::TIME_W-1:0]           req_now_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bte_pkg::EST_W-1:0]            rsp_estimate_bps,
   output logic [bte_pkg::TIME_W-1:0]           rsp_download_time_us,
   output logic                                 rsp_result_kind,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bte_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bte_pkg::ALPHA_W-1:0]          csr_wdata
);

   // sequencer and shared unit operands
   bte_pkg::state_type                 state_ff, state_in;
   logic [bte_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [bte_pkg::ACC_W-1:0]          acc_ff, acc_in;       // product / dividend-quotient
   logic [bte_pkg::ACC_W-1:0]          mcand_ff, mcand_in;
   logic [bte_pkg::ALPHA_W-1:0]        mplier_ff, mplier_in;
   logic [bte_pkg::TIME_W-1:0]         rem_ff, rem_in;
   logic [bte_pkg::TIME_W-1:0]         divisor_ff, divisor_in;
   logic [bte_pkg::EST_W-1:0]          sample_ff, sample_in;
   logic [bte_pkg::TIME_W-1:0]         elapsed_ff, elapsed_in;
   logic [bte_pkg::TIME_W-1:0]         now_ff, now_in;
   logic                               fin_kind_ff, fin_kind_in;
   logic [bte_pkg::ALPHA_W-1:0]        alpha_next_ff, alpha_next_in;

   // architectural state
   logic [bte_pkg::EST_W-1:0]          est_ff, est_in;
   logic [bte_pkg::ALPHA_W-1:0]        cur_alpha_ff, cur_alpha_in;
   logic [bte_pkg::BATCH_W-1:0]        pc_ff, pc_in;
   logic [bte_pkg::TOTAL_W-1:0]        bytes_ff, bytes_in;
   logic [bte_pkg::TIME_W-1:0]         start_ff, start_in;
   logic [bte_pkg::TIME_W-1:0]         batch_begin_ff, batch_begin_in;
   logic [bte_pkg::ALPHA_W-1:0]        base_alpha_ff, base_alpha_in;
   logic [bte_pkg::BATCH_W-1:0]        batch_size_ff, batch_size_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bte_pkg::EST_W-1:0]          rsp_est_ff, rsp_est_in;
   logic [bte_pkg::TIME_W-1:0]         rsp_time_ff, rsp_time_in;
   logic                               rsp_kind_ff, rsp_kind_in;

   // shared adder/subtractor
   logic [bte_pkg::ACC_W-1:0]          add_a, add_b;
   logic                               add_sub;
   logic [bte_pkg::ACC_W:0]            add_sum;
   logic [bte_pkg::ACC_W-1:0]          mult_acc_next;
   logic                               div_ge;
   logic [bte_pkg::TIME_W-1:0]         div_rem_next;
   logic [bte_pkg::ACC_W-1:0]          div_acc_next;

   logic                               req_fire, csr_fire, last_step;
   logic [bte_pkg::BATCH_W-1:0]        pc_inc;
   logic [bte_pkg::TOTAL_W:0]          bytes_sum;
   logic [bte_pkg::TIME_W-1:0]         req_elapsed;
   logic                               est_done;
   logic [bte_pkg::EST_W-1:0]          est_value;
   logic [bte_pkg::ALPHA_DIV_STEPS-1:0] alpha_q;
   logic [bte_pkg::SAMPLE_DIV_STEPS-1:0] sample_q;

   assign req_ready            = (state_ff == bte_pkg::ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_estimate_bps     = rsp_est_ff;
   assign rsp_download_time_us = rsp_time_ff;
   assign rsp_result_kind      = rsp_kind_ff;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign last_step = (cnt_ff == '0);
   assign pc_inc    = pc_ff + 16'd1;
   assign bytes_sum = {1'b0, bytes_ff} + {25'd0, req_packet_bytes};
   assign req_elapsed = (req_kind == bte_pkg::KIND_FINISH) ? (req_now_us - start_ff)
                                                          : (req_now_us - batch_begin_ff);

   // One adder for both shift-add multiply and restoring divide steps
   always_comb begin
      if (state_ff == bte_pkg::ST_DIV_SAMPLE || state_ff == bte_pkg::ST_ALPHA_DIV) begin
         add_a   = {31'd0, rem_ff, acc_ff[bte_pkg::ACC_W-1]};
         add_b   = {32'd0, divisor_ff};
         add_sub = 1'b1;
      end else begin
         add_a   = acc_ff;
         add_b   = mcand_ff;
         add_sub = 1'b0;
      end
      add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                + {{bte_pkg::ACC_W{1'b0}}, add_sub};
   end

   assign mult_acc_next = mplier_ff[0] ? add_sum[bte_pkg::ACC_W-1:0] : acc_ff;
   assign div_ge        = add_sum[bte_pkg::ACC_W];   // no borrow
   assign div_rem_next  = div_ge ? add_sum[bte_pkg::TIME_W-1:0]
                                 : {rem_ff[bte_pkg::TIME_W-2:0], acc_ff[bte_pkg::ACC_W-1]};
   assign div_acc_next  = {acc_ff[bte_pkg::ACC_W-2:0], div_ge};
   assign sample_q      = div_acc_next[bte_pkg::SAMPLE_DIV_STEPS-1:0];
   assign alpha_q       = div_acc_next[bte_pkg::ALPHA_DIV_STEPS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bte_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         est_ff         <= '0;
         cur_alpha_ff   <= '0;
         pc_ff          <= '0;
         bytes_ff       <= '0;
         start_ff       <= '0;
         batch_begin_ff <= '0;
         base_alpha_ff  <= '0;
         batch_size_ff  <= bte_pkg::BATCH_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         est_ff         <= est_in;
         cur_alpha_ff   <= cur_alpha_in;
         pc_ff          <= pc_in;
         bytes_ff       <= bytes_in;
         start_ff       <= start_in;
         batch_begin_ff <= batch_begin_in;
         base_alpha_ff  <= base_alpha_in;
         batch_size_ff  <= batch_size_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      sample_ff     <= sample_in;
      elapsed_ff    <= elapsed_in;
      now_ff        <= now_in;
      fin_kind_ff   <= fin_kind_in;
      alpha_next_ff <= alpha_next_in;
      rsp_est_ff    <= rsp_est_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      sample_in      = sample_ff;
      elapsed_in     = elapsed_ff;
      now_in         = now_ff;
      fin_kind_in    = fin_kind_ff;
      alpha_next_in  = alpha_next_ff;
      est_in         = est_ff;
      cur_alpha_in   = cur_alpha_ff;
      pc_in          = pc_ff;
      bytes_in       = bytes_ff;
      start_in       = start_ff;
      batch_begin_in = batch_begin_ff;
      base_alpha_in  = base_alpha_ff;
      batch_size_in  = batch_size_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_est_in     = rsp_est_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_kind_in    = rsp_kind_ff;
      est_done       = 1'b0;
      est_value      = est_ff;

      if (csr_fire) begin
         unique case (csr_index)
            bte_pkg::CSR_BASE_ALPHA: base_alpha_in = csr_wdata;
            bte_pkg::CSR_BATCH_SIZE: batch_size_in = csr_wdata[bte_pkg::BATCH_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         bte_pkg::ST_IDLE: begin
            if (req_fire) begin
               // set up the scaling multiply in case a sample is due
               acc_in      = '0;
               mcand_in    = {24'd0, bytes_ff};
               mplier_in   = bte_pkg::SCALE_MULT;
               cnt_in      = bte_pkg::CNT_W'(bte_pkg::SCALE_STEPS - 1);
               elapsed_in  = req_elapsed;
               divisor_in  = (req_elapsed == '0) ? 32'd1 : req_elapsed;
               now_in      = req_now_us;
               fin_kind_in = (req_kind == bte_pkg::KIND_FINISH);
               unique case (req_kind)
                  bte_pkg::KIND_START: begin
                     pc_in          = '0;
                     bytes_in       = '0;
                     start_in       = req_now_us;
                     batch_begin_in = req_now_us;
                  end
                  bte_pkg::KIND_DATA: begin
                     bytes_in = bytes_sum[bte_pkg::TOTAL_W] ? {bte_pkg::TOTAL_W{1'b1}}
                                                           : bytes_sum[bte_pkg::TOTAL_W-1:0];
                  end
                  bte_pkg::KIND_RTT: begin
                     pc_in = pc_inc;
                     if (pc_inc == batch_size_ff) begin
                        state_in = bte_pkg::ST_SCALE;
                     end
                  end
                  bte_pkg::KIND_FINISH: begin
                     state_in = bte_pkg::ST_SCALE;
                  end
                  default: ;
               endcase
            end
         end

         bte_pkg::ST_SCALE, bte_pkg::ST_WEIGHT_OLD, bte_pkg::ST_WEIGHT_NEW,
         bte_pkg::ST_ALPHA_MUL: begin
            acc_in    = mult_acc_next;
            mcand_in  = {mcand_ff[bte_pkg::ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[bte_pkg::ALPHA_W-1:1]};
            cnt_in    = cnt_ff - 1'b1;
            if (last_step) begin
               unique case (state_ff)
                  bte_pkg::ST_SCALE: begin
                     // dividend is 63 bits in acc[63:1]; bottom bit of acc stays zero
                     acc_in   = mult_acc_next << (bte_pkg::SCALE_SHIFT + 1);
                     rem_in   = '0;
                     cnt_in   = bte_pkg::CNT_W'(bte_pkg::SAMPLE_DIV_STEPS - 1);
                     state_in = bte_pkg::ST_DIV_SAMPLE;
                  end
                  bte_pkg::ST_WEIGHT_OLD: begin
                     mcand_in  = {16'd0, sample_ff};
                     mplier_in = bte_pkg::ALPHA_ONE - cur_alpha_ff;
                     cnt_in    = bte_pkg::CNT_W'(bte_pkg::WEIGHT_STEPS - 1);
                     state_in  = bte_pkg::ST_WEIGHT_NEW;
                  end
                  bte_pkg::ST_WEIGHT_NEW: begin
                     est_done  = 1'b1;
                     est_value = mult_acc_next[bte_pkg::ACC_W-1:16];
                  end
                  default: begin
                     // alpha product is 33 bits: align to the top of acc
                     acc_in   = mult_acc_next << (bte_pkg::ACC_W - bte_pkg::ALPHA_DIV_STEPS);
                     rem_in   = '0;
                     cnt_in   = bte_pkg::CNT_W'(bte_pkg::ALPHA_DIV_STEPS - 1);
                     state_in = bte_pkg::ST_ALPHA_DIV;
                  end
               endcase
            end
         end

         bte_pkg::ST_DIV_SAMPLE, bte_pkg::ST_ALPHA_DIV: begin
            acc_in = div_acc_next;
            rem_in = div_rem_next;
            cnt_in = cnt_ff - 1'b1;
            if (last_step) begin
               if (state_ff == bte_pkg::ST_DIV_SAMPLE) begin
                  sample_in = (|sample_q[bte_pkg::SAMPLE_DIV_STEPS-1:bte_pkg::EST_W])
                              ? {bte_pkg::EST_W{1'b1}} : sample_q[bte_pkg::EST_W-1:0];
                  if (est_ff == '0) begin
                     est_done  = 1'b1;
                     est_value = sample_in;
                  end else begin
                     acc_in    = '0;
                     mcand_in  = {16'd0, est_ff};
                     mplier_in = cur_alpha_ff;
                     cnt_in    = bte_pkg::CNT_W'(bte_pkg::WEIGHT_STEPS - 1);
                     state_in  = bte_pkg::ST_WEIGHT_OLD;
                  end
               end else begin
                  alpha_next_in = (alpha_q > 33'(bte_pkg::ALPHA_ONE))
                                  ? bte_pkg::ALPHA_ONE : alpha_q[bte_pkg::ALPHA_W-1:0];
                  state_in      = bte_pkg::ST_FINISH;
               end
            end
         end

         bte_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_est_in     = est_ff;
               rsp_time_in    = fin_kind_ff ? elapsed_ff : '0;
               rsp_kind_in    = fin_kind_ff ? bte_pkg::RESULT_DOWNLOAD
                                            : bte_pkg::RESULT_BATCH;
               cur_alpha_in   = alpha_next_ff;
               pc_in          = '0;
               bytes_in       = '0;
               batch_begin_in = now_ff;
               if (fin_kind_ff) begin
                  start_in = now_ff;
               end
               state_in = bte_pkg::ST_IDLE;
            end
         end

         default: state_in = bte_pkg::ST_IDLE;
      endcase

      // estimate settled: a download finish rescales alpha, a batch takes base
      if (est_done) begin
         est_in = est_value;
         if (fin_kind_ff) begin
            acc_in     = '0;
            mcand_in   = {47'd0, bte_pkg::clamp_alpha(base_alpha_ff)};
            mplier_in  = {1'b0, pc_ff};
            divisor_in = (batch_size_ff == '0) ? 32'd1 : {16'd0, batch_size_ff};
            cnt_in     = bte_pkg::CNT_W'(bte_pkg::COUNT_MUL_STEPS - 1);
            state_in   = bte_pkg::ST_ALPHA_MUL;
         end else begin
            alpha_next_in = bte_pkg::clamp_alpha(base_alpha_ff);
            state_in      = bte_pkg::ST_FINISH;
         end
      end
   end

endmodule

// ----- rtl/core/bte_checker.sv -----
// Port-level checks of the batched throughput estimator, bound to the top level.
module bte_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [bte_pkg::EST_W-1:0]            rsp_estimate_bps,
   input  logic [bte_pkg::TIME_W-1:0]           rsp_download_time_us,
   input  logic                                 rsp_result_kind
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate_bps)
                                  && $stable(rsp_result_kind))
      else $error("stalled result changed");

   // batch results carry no download time
   a_batch_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == bte_pkg::RESULT_BATCH |-> rsp_download_time_us == '0)
      else $error("batch result with download time");

   // start and data items leave the block ready in the next cycle
   a_quick_items: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == bte_pkg::KIND_START ||
                                 req_kind == bte_pkg::KIND_DATA) |=> req_ready)
      else $error("short item left the block busy");

   // a fresh result only follows a busy cycle
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result without computation");

   // reset leaves no result and an idle block
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the block");

endmodule

bind batched_throughput_estimator_top bte_checker u_bte_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for the batched throughput estimator top level.
`timescale 1ns / 100ps

module tb;

   localparam int          CLOCK_PERIOD  = 20;
   localparam int          RESET_CYCLES  = 12;
   // Margin after drains for the longest accept-to-result computation.
   localparam int          SETTLE_CYCLES = 200;
   localparam int          CYCLE_LIMIT   = 1_500_000;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_ITEMS   = 95;
   localparam int          REPORT_LIMIT  = 10;
   localparam logic [63:0] BITS_PER_US   = 64'd8_000_000;
   localparam logic [bte_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 4'hF;

   // Expected content of one result item.
   typedef struct packed {
      logic [bte_pkg::EST_W-1:0]  estimate_bps;
      logic [bte_pkg::TIME_W-1:0] download_time_us;
      logic                       result_kind;
   } rate_report_type;

   // Tracks the estimator state and the reports it owes.
   class throughput_tracker_type;
      logic [bte_pkg::ALPHA_W-1:0] base_alpha;
      logic [bte_pkg::ALPHA_W-1:0] cur_alpha;
      logic [bte_pkg::BATCH_W-1:0] batch_size;
      logic [bte_pkg::BATCH_W-1:0] packet_count;
      logic [bte_pkg::EST_W-1:0]   estimate;
      logic [bte_pkg::TOTAL_W-1:0] byte_total;
      logic [bte_pkg::TIME_W-1:0]  start_us;
      logic [bte_pkg::TIME_W-1:0]  batch_start_us;
      rate_report_type             owed_reports[$];
      int                          mismatches;
      int                          batch_reports;
      int                          download_reports;

      function new();
         base_alpha       = '0;
         cur_alpha        = '0;
         batch_size       = bte_pkg::BATCH_RESET;
         packet_count     = '0;
         estimate         = '0;
         byte_total       = '0;
         start_us         = '0;
         batch_start_us   = '0;
         mismatches       = 0;
         batch_reports    = 0;
         download_reports = 0;
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction

      function void set_reg(input logic [bte_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bte_pkg::ALPHA_W-1:0] data);
         case (idx)
            bte_pkg::CSR_BASE_ALPHA: base_alpha = data;
            bte_pkg::CSR_BATCH_SIZE: batch_size = data[bte_pkg::BATCH_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [bte_pkg::ALPHA_W-1:0] cap_weight(input logic [63:0] w);
         return (w > 64'(bte_pkg::ALPHA_ONE)) ? bte_pkg::ALPHA_ONE : w[bte_pkg::ALPHA_W-1:0];
      endfunction

      // New rate sample over the given span, blended into the running estimate.
      function void fold(input logic [bte_pkg::TIME_W-1:0] elapsed);
         logic [63:0]                 divisor;
         logic [63:0]                 sample;
         logic [65:0]                 acc;
         logic [bte_pkg::ALPHA_W-1:0] a;
         divisor = (elapsed == '0) ? 64'd1 : 64'(elapsed);
         sample  = (64'(byte_total) * BITS_PER_US) / divisor;
         if (sample > 64'({bte_pkg::EST_W{1'b1}})) sample = 64'({bte_pkg::EST_W{1'b1}});
         if (estimate != '0) begin
            a        = cap_weight(64'(cur_alpha));
            acc      = 66'(a) * 66'(estimate)
                       + (66'(bte_pkg::ALPHA_ONE) - 66'(a)) * 66'(sample);
            estimate = acc[63:16];
         end else begin
            estimate = sample[bte_pkg::EST_W-1:0];
         end
      endfunction

      function void note_event(input logic [1:0] kind,
                               input logic [bte_pkg::BYTES_W-1:0] nbytes,
                               input logic [bte_pkg::TIME_W-1:0] stamp);
         logic [bte_pkg::TOTAL_W:0]   sum;
         logic [bte_pkg::TIME_W-1:0]  elapsed;
         logic [63:0]                 divisor;
         logic [63:0]                 weight;
         case (kind)
            bte_pkg::KIND_START: begin
               packet_count   = '0;
               byte_total     = '0;
               start_us       = stamp;
               batch_start_us = stamp;
            end
            bte_pkg::KIND_DATA: begin
               sum        = {1'b0, byte_total} + (bte_pkg::TOTAL_W + 1)'(nbytes);
               byte_total = sum[bte_pkg::TOTAL_W] ? {bte_pkg::TOTAL_W{1'b1}}
                                                  : sum[bte_pkg::TOTAL_W-1:0];
            end
            bte_pkg::KIND_RTT: begin
               packet_count = packet_count + 1'b1;
               if (packet_count == batch_size) begin
                  fold(stamp - batch_start_us);
                  cur_alpha      = cap_weight(64'(base_alpha));
                  packet_count   = '0;
                  byte_total     = '0;
                  batch_start_us = stamp;
                  owed_reports.push_back('{estimate, '0, bte_pkg::RESULT_BATCH});
               end
            end
            default: begin
               elapsed = stamp - start_us;
               divisor = (batch_size == '0) ? 64'd1 : 64'(batch_size);
               fold(elapsed);
               weight         = 64'(cap_weight(64'(base_alpha))) * 64'(packet_count) / divisor;
               cur_alpha      = cap_weight(weight);
               packet_count   = '0;
               byte_total     = '0;
               start_us       = stamp;
               batch_start_us = stamp;
               owed_reports.push_back('{estimate, elapsed, bte_pkg::RESULT_DOWNLOAD});
            end
         endcase
      endfunction

      function void check_result(input logic [bte_pkg::EST_W-1:0] est,
                                 input logic [bte_pkg::TIME_W-1:0] dur,
                                 input logic kind);
         rate_report_type want;
         if (owed_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result est=%0d dur=%0d kind=%0d",
                        $realtime, est, dur, kind);
            return;
         end
         want = owed_reports.pop_front();
         if (want.result_kind == bte_pkg::RESULT_BATCH) batch_reports++;
         else download_reports++;
         if (want.estimate_bps !== est || want.download_time_us !== dur ||
             want.result_kind !== kind) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"%0t: mismatch est exp %0d got %0d, dur exp %0d got %0d, ",
                         "kind exp %0d got %0d"},
                        $realtime, want.estimate_bps, est, want.download_time_us, dur,
                        want.result_kind, kind);
         end
      endfunction
   endclass

   // DUT-facing signals; every input starts at a known value.
   logic                          clock                = 1'b0;
   logic                          reset                = 1'b1;
   logic                          req_valid            = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_kind             = bte_pkg::KIND_START;
   logic [bte_pkg::BYTES_W-1:0]   req_packet_bytes     = '0;
   logic [bte_pkg::TIME_W-1:0]    req_now_us           = '0;
   logic                          rsp_valid;
   logic                          rsp_ready            = 1'b0;
   logic [bte_pkg::EST_W-1:0]     rsp_estimate_bps;
   logic [bte_pkg::TIME_W-1:0]    rsp_download_time_us;
   logic                          rsp_result_kind;
   logic                          csr_valid            = 1'b0;
   logic                          csr_ready;
   logic [bte_pkg::CSR_IDX_W-1:0] csr_index            = bte_pkg::CSR_BASE_ALPHA;
   logic [bte_pkg::ALPHA_W-1:0]   csr_wdata            = '0;

   throughput_tracker_type     sb;
   int                         sender_idle_pct    = 0;
   int                         receiver_stall_pct = 0;
   int                         items_sent         = 0;
   int                         settings_used      = 0;
   int                         cycles             = 0;
   logic [bte_pkg::TIME_W-1:0] clock_us           = '0;

   batched_throughput_estimator_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_packet_bytes     (req_packet_bytes),
      .req_now_us           (req_now_us),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_estimate_bps     (rsp_estimate_bps),
      .rsp_download_time_us (rsp_download_time_us),
      .rsp_result_kind      (rsp_result_kind),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: check every accepted item, then pick next cycle's ready.
   // Sampling happens before this edge's updates land, so no race with the DUT.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_estimate_bps, rsp_download_time_us, rsp_result_kind);
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Present one event item, with an optional random gap in front of it.
   // Valid is only dropped during a gap, so it never toggles within one step.
   task automatic send_event(input logic [1:0] kind,
                             input logic [bte_pkg::BYTES_W-1:0] nbytes,
                             input logic [bte_pkg::TIME_W-1:0] stamp);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_packet_bytes <= nbytes;
      req_now_us       <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_event(kind, nbytes, stamp);
      items_sent++;
   endtask

   // Register write; csr_valid is dropped by the caller after the last write.
   task automatic write_csr(input logic [bte_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bte_pkg::ALPHA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic set_regs(input logic [bte_pkg::ALPHA_W-1:0] alpha,
                           input logic [bte_pkg::ALPHA_W-1:0] batch);
      write_csr(bte_pkg::CSR_BASE_ALPHA, alpha);
      write_csr(bte_pkg::CSR_BATCH_SIZE, batch);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Wait for every owed result, then let the sequencer run dry before any
   // register write (a finish can still be in flight after the last result).
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
         default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
      endcase
   endtask

   // Mostly short steps so samples stay in range; zero steps, long jumps and
   // arbitrary timestamps (including wrap-around) mixed in.
   function automatic logic [bte_pkg::TIME_W-1:0] next_stamp(
         input logic [bte_pkg::TIME_W-1:0] cur);
      case ($urandom_range(9))
         0:       return cur;
         1, 2, 3: return cur + $urandom_range(1, 200);
         4, 5:    return cur + $urandom_range(201, 5000);
         6, 7:    return cur + $urandom_range(5001, 1_000_000);
         8:       return cur + $urandom;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [bte_pkg::BYTES_W-1:0] rand_bytes();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return bte_pkg::BYTES_W'($urandom);
      endcase
   endfunction

   // Mostly well-formed downloads (start, data and rtt mix, finish);
   // some stray starts/finishes inside, and some fully random items.
   task automatic random_session();
      int n;
      int pick;
      if ($urandom_range(9) < 8) begin
         clock_us = next_stamp(clock_us);
         send_event(bte_pkg::KIND_START, rand_bytes(), clock_us);
         n = $urandom_range(1, 24);
         repeat (n) begin
            pick     = $urandom_range(99);
            clock_us = next_stamp(clock_us);
            if (pick < 50)      send_event(bte_pkg::KIND_DATA, rand_bytes(), clock_us);
            else if (pick < 95) send_event(bte_pkg::KIND_RTT, rand_bytes(), clock_us);
            else if (pick < 97) send_event(bte_pkg::KIND_START, rand_bytes(), clock_us);
            else                send_event(bte_pkg::KIND_FINISH, rand_bytes(), clock_us);
         end
         if ($urandom_range(9) != 0) begin
            clock_us = next_stamp(clock_us);
            send_event(bte_pkg::KIND_FINISH, rand_bytes(), clock_us);
         end
      end else begin
         send_event(2'($urandom_range(3)), bte_pkg::BYTES_W'($urandom),
                    bte_pkg::TIME_W'($urandom));
      end
   endtask

   task automatic directed_checks();
      set_idling(0);
      // base_alpha written before any batch: current weight stays zero until
      // the first batch closes. An unmapped index must be dropped.
      write_csr(bte_pkg::CSR_BASE_ALPHA, 17'h08000);
      write_csr(bte_pkg::CSR_BATCH_SIZE, 17'd2);
      write_csr(CSR_UNMAPPED, '1);
      csr_valid <= 1'b0;
      settings_used++;
      // download finish with no start and no bytes: zero sample
      send_event(bte_pkg::KIND_FINISH, 16'hFFFF, 32'd1000);
      // batch spanning the 32-bit time wrap, byte extremes
      send_event(bte_pkg::KIND_START, 16'h1234, 32'hFFFF_FF00);
      send_event(bte_pkg::KIND_DATA, 16'hFFFF, 32'hFFFF_FF10);
      send_event(bte_pkg::KIND_DATA, 16'h0000, 32'hFFFF_FF20);
      send_event(bte_pkg::KIND_DATA, 16'h0001, 32'hFFFF_FF30);
      send_event(bte_pkg::KIND_RTT, 16'hFFFF, 32'h0000_0100);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0100);
      // zero elapsed batch, EWMA at half weight
      send_event(bte_pkg::KIND_DATA, 16'h8000, 32'h0000_0100);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0100);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0100);
      // finish mid-batch: weight rescaled by packets/batch
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0200);
      send_event(bte_pkg::KIND_FINISH, 16'h0000, 32'h0000_0300);
      // zero-length download
      send_event(bte_pkg::KIND_START, 16'h0000, 32'h7FFF_FFFF);
      send_event(bte_pkg::KIND_DATA, 16'h5555, 32'h7FFF_FFFF);
      send_event(bte_pkg::KIND_FINISH, 16'h0000, 32'h7FFF_FFFF);
      // finish with no packets: weight drops to zero
      send_event(bte_pkg::KIND_FINISH, 16'hAAAA, 32'hFFFF_FFFF);
      settle();

      // full weight on the old estimate, single-packet batches
      set_regs(bte_pkg::ALPHA_ONE, 17'd1);
      send_event(bte_pkg::KIND_DATA, 16'hAAAA, 32'h0000_0400);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0401);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0402);
      settle();
      // out-of-range weight clamps to 1.0
      set_regs('1, 17'd1);
      send_event(bte_pkg::KIND_DATA, 16'h0F0F, 32'h0000_0500);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0510);
      settle();
      set_regs('0, 17'd1);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0520);
      send_event(bte_pkg::KIND_RTT, 16'h0000, 32'h0000_0530);
      settle();

      // Sample saturation: over 35M bytes in a zero-length download.
      send_event(bte_pkg::KIND_START, 16'h0000, 32'h0000_1000);
      repeat (600) send_event(bte_pkg::KIND_DATA, 16'hFFFF, 32'h0000_1000);
      send_event(bte_pkg::KIND_FINISH, 16'h0000, 32'h0000_1000);
      settle();

      // Zero batch size: rtt updates close no batch here, and the weight
      // rescale divides by one and clamps.
      set_regs(17'd40000, 17'd0);
      clock_us = 32'h0010_0000;
      send_event(bte_pkg::KIND_START, 16'h0000, clock_us);
      send_event(bte_pkg::KIND_DATA, 16'h1000, clock_us + 1);
      repeat (3) send_event(bte_pkg::KIND_RTT, 16'h0000, clock_us + 2);
      send_event(bte_pkg::KIND_FINISH, 16'h0000, clock_us + 3);
      settle();
   endtask

   initial begin
      logic [bte_pkg::ALPHA_W-1:0] alpha_pick;
      logic [bte_pkg::ALPHA_W-1:0] batch_pick;
      int                          item_goal;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_checks();

      // Random phases: each one gets fresh registers and its own idling mode.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase % 4)
            0:       alpha_pick = bte_pkg::ALPHA_ONE;
            1:       alpha_pick = '0;
            2:       alpha_pick = bte_pkg::ALPHA_W'($urandom_range(1, 65535));
            default: alpha_pick = bte_pkg::ALPHA_W'($urandom_range(0, 131071));
         endcase
         if (phase == 5)      batch_pick = 17'd65535;
         else if (phase == 6) batch_pick = 17'd1;
         else                 batch_pick = bte_pkg::ALPHA_W'($urandom_range(2, 8));
         if (phase % 3 == 0) write_csr(CSR_UNMAPPED, bte_pkg::ALPHA_W'($urandom));
         set_regs(alpha_pick, batch_pick);
         set_idling(phase % 4);
         item_goal = items_sent + PHASE_ITEMS;
         while (items_sent < item_goal) random_session();
      end

      settle();
      $display("Ran %0d event items under %0d register settings and four idling modes:",
               items_sent, settings_used);
      $display("  %0d batch estimates and %0d download reports checked, %0d mismatches",
               sb.batch_reports, sb.download_reports, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- batched_throughput_estimator_top.f -----
rtl/core/bte_pkg.sv
rtl/core/batched_throughput_estimator_top.sv
rtl/core/bte_checker.sv
test/tb.sv
